[design/orl_pkg.sv]
// Shared types and constants for the overwriting ring log.
// Used by every module of the block but orl_ram; depends on nothing.
`default_nettype none

package orl_pkg;

  localparam int ORL_DEPTH = 64;
  localparam int ORL_REC_W = 64;

  localparam int DATA_W  = 64;
  localparam int COUNT_W = 7;
  localparam int LIMIT_W = 7;
  localparam int KIND_W  = 2;
  localparam int TDATA_W = 72;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_LATEST = 2'd1,
    KIND_CHRON  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef struct packed {
    logic do_append;
    logic do_clear;
    logic start_read;
    logic ram_rd;
    logic advance;
    logic load_empty;
    logic load_rec;
  } orl_cmd_t;

  typedef struct packed {
    logic empty_read;
    logic last_rec;
  } orl_status_t;

endpackage

`default_nettype wire

[design/orl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module orl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/orl_dpath.sv]
// Datapath of the ring log: write pointer, count, read cursor, record RAM and
// the output register. Depends on orl_pkg and orl_ram.
`default_nettype none

module orl_dpath
  import orl_pkg::*;
#(
  parameter int DEPTH = ORL_DEPTH,
  parameter int REC_W = ORL_REC_W
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire orl_cmd_t           cmd_i,
  input  wire kind_e              kind_i,
  input  wire logic [DATA_W-1:0]  data_i,
  input  wire logic [LIMIT_W-1:0] limit_i,
  output orl_status_t             status_o,
  output logic [DATA_W-1:0]       rec_o,
  output logic                    has_o,
  output logic                    last_o,
  output logic [COUNT_W-1:0]      count_o,
  output logic                    full_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [PW-1:0] wp_q, wp_d, cursor_q, cursor_d, cursor_inc, raddr;
  logic [CW-1:0] count_q, count_d, remain_q, remain_d, n_sel;
  logic [SW-1:0] start_sum;
  logic [REC_W-1:0] ram_dout;
  logic [DATA_W-1:0] rec_ext;

  always_comb begin
    wp_d    = wp_q;
    count_d = count_q;
    if (cmd_i.do_append) begin
      wp_d = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
      if (count_q != CW'(DEPTH)) begin
        count_d = count_q + CW'(1);
      end
    end
    if (cmd_i.do_clear) begin
      wp_d    = '0;
      count_d = '0;
    end
  end

  // The first record to read sits n places behind the write pointer, full or not.
  always_comb begin
    if (kind_i == KIND_LATEST) begin
      n_sel = CW'(1);
    end else if (limit_i < COUNT_W'(count_q)) begin
      n_sel = CW'(limit_i);
    end else begin
      n_sel = count_q;
    end
    start_sum = SW'(wp_q) + SW'(DEPTH) - SW'(n_sel);
    if (start_sum >= SW'(DEPTH)) begin
      start_sum = start_sum - SW'(DEPTH);
    end
  end

  assign status_o.empty_read = (kind_i == KIND_LATEST) ? (count_q == '0) : (n_sel == '0);
  assign status_o.last_rec   = (remain_q == CW'(1));

  assign cursor_inc = (cursor_q == PW'(DEPTH - 1)) ? '0 : cursor_q + PW'(1);
  assign raddr      = cmd_i.advance ? cursor_inc : cursor_q;

  always_comb begin
    cursor_d = cursor_q;
    remain_d = remain_q;
    if (cmd_i.start_read) begin
      cursor_d = PW'(start_sum);
      remain_d = n_sel;
    end else if (cmd_i.advance) begin
      cursor_d = cursor_inc;
      remain_d = remain_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      count_q  <= '0;
      cursor_q <= '0;
      remain_q <= '0;
    end else begin
      wp_q     <= wp_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      remain_q <= remain_d;
    end
  end

  orl_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.do_append),
    .waddr_i (wp_q),
    .wdata_i (data_i[REC_W-1:0]),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (raddr),
    .rdata_o (ram_dout)
  );

  always_comb begin
    rec_ext = '0;
    rec_ext[REC_W-1:0] = ram_dout;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_empty) begin
      rec_o   <= '0;
      has_o   <= 1'b0;
      last_o  <= 1'b1;
      count_o <= COUNT_W'(count_d);
      full_o  <= (count_d == CW'(DEPTH));
    end else if (cmd_i.load_rec) begin
      rec_o   <= rec_ext;
      has_o   <= 1'b1;
      last_o  <= status_o.last_rec;
      count_o <= COUNT_W'(count_q);
      full_o  <= (count_q == CW'(DEPTH));
    end
  end

endmodule

`default_nettype wire

[design/orl_ctrl.sv]
// Controller of the ring log: sequences appends, clears and reads, and owns
// the output valid flag. Depends on orl_pkg.
`default_nettype none

module orl_ctrl
  import orl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  input  wire kind_e       kind_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  input  wire orl_status_t status_i,
  output orl_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_WAIT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   slot_free, s_xfer;

  assign slot_free = !m_valid_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE) && slot_free;
  assign s_xfer    = s_valid_i && s_ready_o;
  assign m_valid_o = m_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          case (kind_i)
            KIND_APPEND: begin
              cmd_o.do_append  = 1'b1;
              cmd_o.load_empty = 1'b1;
            end
            KIND_CLEAR: begin
              cmd_o.do_clear   = 1'b1;
              cmd_o.load_empty = 1'b1;
            end
            default: begin
              if (status_i.empty_read) begin
                cmd_o.load_empty = 1'b1;
              end else begin
                cmd_o.start_read = 1'b1;
                state_d          = ST_FETCH;
              end
            end
          endcase
        end
      end
      ST_FETCH: begin
        cmd_o.ram_rd = 1'b1;
        state_d      = ST_WAIT;
      end
      ST_WAIT: begin
        if (slot_free) begin
          cmd_o.load_rec = 1'b1;
          if (status_i.last_rec) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            cmd_o.ram_rd  = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_valid_d = (m_valid_q && !m_ready_i) || cmd_o.load_empty || cmd_o.load_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

`default_nettype wire

[design/overwriting_ring_log_core.sv]
// Top level of the overwriting ring log: stream ports, controller and datapath.
// Depends on orl_pkg, orl_ctrl, orl_dpath and orl_ram.
//
// A ring of DEPTH records kept in a RAM with a registered read port. Appends,
// clears and reads that return nothing may follow one another in consecutive
// cycles while the output register drains. A latest read or a chronological
// read of n records goes through ST_FETCH, where the RAM is read, and ST_WAIT,
// where the first record is loaded, then delivers one record per cycle while
// the output side takes them; the single RAM read port sets that pace. The next
// input transfer can be taken in the cycle after the last record is loaded, if
// the output side takes that record. Stored words are not cleared by reset or by
// a clear; the count keeps every read on written entries.
`default_nettype none

module overwriting_ring_log_core
  import orl_pkg::*;
#(
  parameter int DEPTH = ORL_DEPTH,
  parameter int REC_W = ORL_REC_W
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // [63:0] record_data, [70:64] read_limit, [71] zero
  input  wire logic [TDATA_W-1:0] s_axis_tdata,
  // [1:0] kind
  input  wire logic [KIND_W-1:0]  s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // [63:0] out_record, [70:64] count_now, [71] ring_full
  output logic [TDATA_W-1:0]      m_axis_tdata,
  // [0] has_record
  output logic                    m_axis_tuser,
  output logic                    m_axis_tlast
);

  orl_cmd_t           cmd;
  orl_status_t        status;
  kind_e              kind;
  logic [DATA_W-1:0]  out_rec;
  logic [COUNT_W-1:0] out_count;
  logic               out_full;

  assign kind = kind_e'(s_axis_tuser);

  orl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .kind_i    (kind),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  orl_dpath #(
    .DEPTH (DEPTH),
    .REC_W (REC_W)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .kind_i   (kind),
    .data_i   (s_axis_tdata[DATA_W-1:0]),
    .limit_i  (s_axis_tdata[DATA_W+LIMIT_W-1:DATA_W]),
    .status_o (status),
    .rec_o    (out_rec),
    .has_o    (m_axis_tuser),
    .last_o   (m_axis_tlast),
    .count_o  (out_count),
    .full_o   (out_full)
  );

  assign m_axis_tdata = {out_full, out_count, out_rec};

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
    else $error("result without a record is not the last of its run");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[71] == (m_axis_tdata[70:64] == COUNT_W'(DEPTH))))
    else $error("ring_full disagrees with count_now");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[70:64] <= COUNT_W'(DEPTH)))
    else $error("count_now exceeds capacity");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (kind == KIND_CLEAR))
    |=> (m_axis_tvalid && (m_axis_tdata[70:64] == '0) && !m_axis_tuser))
    else $error("clear did not report an empty ring");

endmodule

`default_nettype wire
